@@ rtl/kmc_pkg.sv @@
`timescale 1ns / 1ps

package kmc_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_COORD = 2'd0,
        CMD_LOAD_BOUND = 2'd1,
        CMD_RUN        = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd0;
    localparam logic [1:0] CFG_NUM_DIMS     = 2'd1;
    localparam logic [1:0] CFG_RNG_SEED     = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_POINTS = 2'd1;
    localparam logic [1:0] STATUS_DROPPED   = 2'd2;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [3:0] RESET_NUM_CLUSTERS = 4'd2;
    localparam logic [3:0] RESET_NUM_DIMS     = 4'd8;

    // Galois LFSR step: shift right, fold taps in when the old lsb was set
    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        lfsr_step = (s >> 1) ^ (s[0] ? LFSR_TAPS : 32'd0);
    endfunction

endpackage

@@ rtl/kmc_div.sv @@
`timescale 1ns / 1ps

// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncates toward zero.
module kmc_div #(
    parameter int N_W = 25,
    parameter int D_W = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [N_W-1:0] dividend,
    input  logic        [D_W-1:0] divisor,
    output logic                  done,
    output logic signed [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W:0]   rem_reg;
    logic [N_W-1:0] quo_reg;
    logic [D_W-1:0] div_reg;
    logic           neg_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [D_W:0] trial;
    logic         fits;

    assign trial = {rem_reg[D_W-1:0], quo_reg[N_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
                rem_reg  <= '0;
                div_reg  <= divisor;
                neg_reg  <= dividend[N_W-1];
                quo_reg  <= dividend[N_W-1] ? N_W'(-dividend) : N_W'(dividend);
            end else if (busy_reg) begin
                rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
                quo_reg <= {quo_reg[N_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

@@ rtl/kmeans_clustering_multidim_top.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// input    | s_valid / s_ready  | s_command, s_dim_index, s_sample_value,
//          |                    | s_upper_bound_value
// result   | m_valid / m_ready  | m_cluster_index, m_out_dim, m_centroid_value,
//          |                    | m_member_count, m_radius_squared,
//          |                    | m_converged, m_status, m_last
// config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// A run holds s_ready low until its last result is taken. A run seeds each centroid
// coordinate; each pass then clears the sums, assigns every point, updates each
// non-empty cluster (an empty one keeps its centroid) and closes, up to MAX_ITERATIONS
// passes; then one result is offered at a time, held while m_ready is low. Reset
// (aresetn, synchronous, active low) clears control, counts and bounds; the point
// memory is undefined until written.
module kmeans_clustering_multidim_top #(
    parameter int MAX_POINTS     = 256,
    parameter int MAX_CLUSTERS   = 8,
    parameter int MAX_DIMS       = 8,
    parameter int MAX_ITERATIONS = 100
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    // input requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [2:0]         s_dim_index,
    input  logic signed [15:0] s_sample_value,
    input  logic signed [15:0] s_upper_bound_value,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_cluster_index,
    output logic [2:0]         m_out_dim,
    output logic signed [15:0] m_centroid_value,
    output logic [8:0]         m_member_count,
    output logic [34:0]        m_radius_squared,
    output logic               m_converged,
    output logic [1:0]         m_status,
    output logic               m_last
);

    localparam int DIM_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CL_AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int PT_AW  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ND_W   = $clog2(MAX_DIMS + 1);
    localparam int K_W    = $clog2(MAX_CLUSTERS + 1);
    localparam int IT_W   = $clog2(MAX_ITERATIONS + 1);
    localparam int SUM_W  = 17 + PT_AW;
    localparam int DIST_W = 32 + $clog2(MAX_DIMS);
    localparam int PM_DEPTH = MAX_POINTS * (1 << DIM_AW);
    localparam int CM_DEPTH = (1 << CL_AW) * (1 << DIM_AW);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SEED_MUL, ST_SEED_WR, ST_CLR, ST_DIST_RD, ST_DIST_MUL,
        ST_DIST_ACC, ST_ASSIGN, ST_UPD_RD, ST_UPD_WR, ST_NEW_CHK, ST_NEW_RD,
        ST_NEW_DIV, ST_NEW_WAIT, ST_ITER, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
    } state_t;

    state_t state_reg;

    // configuration and loaded state
    logic [3:0]  num_clusters_reg;
    logic [3:0]  num_dims_reg;
    logic [31:0] lfsr_reg;
    logic [CNT_W-1:0] pcount_reg;
    logic        dropped_reg;
    logic [15:0] lo_reg [MAX_DIMS];
    logic [15:0] hi_reg [MAX_DIMS];

    // run state
    logic [CL_AW-1:0]  c_reg;
    logic [DIM_AW-1:0] d_reg;
    logic [CNT_W-1:0]  p_reg;
    logic [IT_W-1:0]   iter_reg;
    logic              conv_reg;
    logic [CNT_W-1:0]  cnt_reg [MAX_CLUSTERS];
    logic [DIST_W-1:0] rad_reg [MAX_CLUSTERS];
    logic signed [49:0] prod_reg;
    logic [31:0]       sq_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] best_reg;
    logic [CL_AW-1:0]  best_c_reg;

    // result register
    logic        m_valid_reg;
    logic [2:0]  m_cluster_reg;
    logic [2:0]  m_dim_reg;
    logic [15:0] m_value_reg;
    logic [8:0]  m_count_reg;
    logic [34:0] m_rad_reg;
    logic        m_conv_reg;
    logic [1:0]  m_status_reg;
    logic        m_last_reg;

    // memories
    logic [15:0]      pm_mem [PM_DEPTH];
    logic [15:0]      pm_q;
    logic             pm_we;
    logic [PT_AW+DIM_AW-1:0] pm_waddr;
    logic [15:0]      cm_mem [CM_DEPTH];
    logic [15:0]      cm_q;
    logic             cm_we;
    logic [15:0]      cm_wdata;
    logic [SUM_W-1:0] sm_mem [CM_DEPTH];
    logic [SUM_W-1:0] sm_q;
    logic             sm_we;
    logic [SUM_W-1:0] sm_wdata;
    logic [CL_AW-1:0] sm_rc;
    logic [CL_AW-1:0] sm_wc;

    // clamped run sizes
    logic [K_W-1:0]  k_eff;
    logic [ND_W-1:0] nd_eff;
    logic            d_last;
    logic            c_last;
    logic            accept;
    logic            dim_ok;
    logic            room;
    logic            pt_done;

    logic [CL_AW-1:0]  cl_idx;
    logic [31:0]       lfsr_nx;
    logic signed [16:0] span;
    logic signed [49:0] seed_prod;
    logic signed [17:0] seed_sum;
    logic signed [16:0] diff;
    logic [DIST_W-1:0] acc_sum;
    logic [DIST_W-1:0] rad_max;

    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_q;
    logic [15:0]             new_c;

    always_comb begin
        if (num_clusters_reg == 4'd0) k_eff = K_W'(1);
        else if (32'(num_clusters_reg) > MAX_CLUSTERS) k_eff = K_W'(MAX_CLUSTERS);
        else k_eff = K_W'(num_clusters_reg);
        if (num_dims_reg == 4'd0) nd_eff = ND_W'(1);
        else if (32'(num_dims_reg) > MAX_DIMS) nd_eff = ND_W'(MAX_DIMS);
        else nd_eff = ND_W'(num_dims_reg);
    end

    assign d_last  = 32'(d_reg) == 32'(nd_eff) - 1;
    assign c_last  = 32'(c_reg) == 32'(k_eff) - 1;
    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;
    assign dim_ok  = 32'(s_dim_index) < MAX_DIMS;
    assign room    = 32'(pcount_reg) < MAX_POINTS;
    assign pt_done = 32'(s_dim_index) == 32'(nd_eff) - 1;

    // counts and radii share one index: the winner during assignment,
    // the cluster counter otherwise
    assign cl_idx = (state_reg == ST_ASSIGN) ? best_c_reg : c_reg;

    // seeding: lo + floor(span * r / 2^32)
    assign lfsr_nx   = kmc_pkg::lfsr_step(lfsr_reg);
    assign span      = $signed({hi_reg[d_reg][15], hi_reg[d_reg]})
                     - $signed({lo_reg[d_reg][15], lo_reg[d_reg]});
    assign seed_prod = span * $signed({1'b0, lfsr_nx});
    assign seed_sum  = $signed({{2{lo_reg[d_reg][15]}}, lo_reg[d_reg]})
                     + prod_reg[49:32];

    assign diff    = $signed({pm_q[15], pm_q}) - $signed({cm_q[15], cm_q});
    assign acc_sum = acc_reg + DIST_W'(sq_reg);
    assign rad_max = (best_reg > rad_reg[best_c_reg]) ? best_reg : rad_reg[best_c_reg];
    assign new_c   = div_q[15:0];

    // memory control
    assign pm_we    = accept && (s_command == kmc_pkg::CMD_LOAD_COORD) && dim_ok && room;
    assign pm_waddr = {pcount_reg[PT_AW-1:0], DIM_AW'(s_dim_index)};

    always_comb begin
        cm_we    = 1'b0;
        cm_wdata = seed_sum[15:0];
        if (state_reg == ST_SEED_WR) cm_we = 1'b1;
        if (state_reg == ST_NEW_WAIT && div_done) begin
            cm_we    = 1'b1;
            cm_wdata = new_c;
        end
    end

    assign sm_rc     = (state_reg == ST_NEW_RD) ? c_reg : best_c_reg;
    assign sm_wc     = (state_reg == ST_CLR) ? c_reg : best_c_reg;
    assign sm_we     = (state_reg == ST_CLR) || (state_reg == ST_UPD_WR);
    assign sm_wdata  = (state_reg == ST_CLR) ? '0 : sm_q + SUM_W'($signed(pm_q));
    assign div_start = state_reg == ST_NEW_DIV;

    always_ff @(posedge aclk) begin
        if (pm_we) pm_mem[pm_waddr] <= s_sample_value;
        pm_q <= pm_mem[{p_reg[PT_AW-1:0], d_reg}];
    end

    always_ff @(posedge aclk) begin
        if (cm_we) cm_mem[{c_reg, d_reg}] <= cm_wdata;
        cm_q <= cm_mem[{c_reg, d_reg}];
    end

    always_ff @(posedge aclk) begin
        if (sm_we) sm_mem[{sm_wc, d_reg}] <= sm_wdata;
        sm_q <= sm_mem[{sm_rc, d_reg}];
    end

    kmc_div #(
        .N_W (SUM_W),
        .D_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ($signed(sm_q)),
        .divisor  (cnt_reg[c_reg]),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            num_clusters_reg <= kmc_pkg::RESET_NUM_CLUSTERS;
            num_dims_reg     <= kmc_pkg::RESET_NUM_DIMS;
            lfsr_reg         <= 32'd1;
            pcount_reg       <= '0;
            dropped_reg      <= 1'b0;
            c_reg            <= '0;
            d_reg            <= '0;
            p_reg            <= '0;
            iter_reg         <= '0;
            conv_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                cnt_reg[i] <= '0;
                rad_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    kmc_pkg::CFG_NUM_CLUSTERS: num_clusters_reg <= cfg_wdata[3:0];
                    kmc_pkg::CFG_NUM_DIMS:     num_dims_reg     <= cfg_wdata[3:0];
                    kmc_pkg::CFG_RNG_SEED:
                        lfsr_reg <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_command)
                            kmc_pkg::CMD_LOAD_COORD: begin
                                if (dim_ok && pt_done) begin
                                    if (room) pcount_reg <= pcount_reg + 1'b1;
                                    else dropped_reg <= 1'b1;
                                end
                            end
                            kmc_pkg::CMD_LOAD_BOUND: begin
                                if (dim_ok) begin
                                    lo_reg[DIM_AW'(s_dim_index)] <= s_sample_value;
                                    hi_reg[DIM_AW'(s_dim_index)] <= s_upper_bound_value;
                                end
                            end
                            kmc_pkg::CMD_CLEAR: begin
                                pcount_reg  <= '0;
                                dropped_reg <= 1'b0;
                            end
                            default: begin
                                c_reg     <= '0;
                                d_reg     <= '0;
                                state_reg <= ST_SEED_MUL;
                            end
                        endcase
                    end
                end
                ST_SEED_MUL: begin
                    lfsr_reg  <= lfsr_nx;
                    prod_reg  <= seed_prod;
                    state_reg <= ST_SEED_WR;
                end
                ST_SEED_WR: begin
                    state_reg <= ST_SEED_MUL;
                    if (d_last) begin
                        cnt_reg[cl_idx] <= '0;
                        rad_reg[cl_idx] <= '0;
                        d_reg <= '0;
                        if (c_last) begin
                            c_reg     <= '0;
                            iter_reg  <= '0;
                            conv_reg  <= 1'b0;
                            state_reg <= ST_CLR;
                        end else begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                // zero sums and counts for the new pass
                ST_CLR: begin
                    if (d_reg == '0) cnt_reg[cl_idx] <= '0;
                    if (d_last) begin
                        d_reg <= '0;
                        if (c_last) begin
                            c_reg   <= '0;
                            p_reg   <= '0;
                            acc_reg <= '0;
                            if (pcount_reg == '0) begin
                                conv_reg  <= 1'b1;
                                state_reg <= ST_NEW_CHK;
                            end else begin
                                state_reg <= ST_DIST_RD;
                            end
                        end else begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                ST_DIST_RD:  state_reg <= ST_DIST_MUL;
                ST_DIST_MUL: begin
                    sq_reg    <= 32'(diff * diff);
                    state_reg <= ST_DIST_ACC;
                end
                ST_DIST_ACC: begin
                    state_reg <= ST_DIST_RD;
                    if (d_last) begin
                        // strict compare keeps the lowest index on ties
                        if (c_reg == '0 || acc_sum < best_reg) begin
                            best_reg   <= acc_sum;
                            best_c_reg <= c_reg;
                        end
                        d_reg   <= '0;
                        acc_reg <= '0;
                        if (c_last) state_reg <= ST_ASSIGN;
                        else c_reg <= c_reg + 1'b1;
                    end else begin
                        acc_reg <= acc_sum;
                        d_reg   <= d_reg + 1'b1;
                    end
                end
                ST_ASSIGN: begin
                    rad_reg[cl_idx] <= rad_max;
                    cnt_reg[cl_idx] <= cnt_reg[cl_idx] + 1'b1;
                    d_reg     <= '0;
                    state_reg <= ST_UPD_RD;
                end
                ST_UPD_RD: state_reg <= ST_UPD_WR;
                ST_UPD_WR: begin
                    state_reg <= ST_UPD_RD;
                    if (d_last) begin
                        d_reg <= '0;
                        c_reg <= '0;
                        if (p_reg == pcount_reg - 1'b1) begin
                            conv_reg  <= 1'b1;
                            state_reg <= ST_NEW_CHK;
                        end else begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= ST_DIST_RD;
                        end
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                // empty clusters keep their centroid
                ST_NEW_CHK: begin
                    d_reg <= '0;
                    if (cnt_reg[cl_idx] != '0) begin
                        state_reg <= ST_NEW_RD;
                    end else if (c_last) begin
                        state_reg <= ST_ITER;
                    end else begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_NEW_RD:  state_reg <= ST_NEW_DIV;
                ST_NEW_DIV: state_reg <= ST_NEW_WAIT;
                ST_NEW_WAIT: begin
                    if (div_done) begin
                        if (new_c != cm_q) conv_reg <= 1'b0;
                        if (d_last) begin
                            d_reg <= '0;
                            if (c_last) begin
                                state_reg <= ST_ITER;
                            end else begin
                                c_reg     <= c_reg + 1'b1;
                                state_reg <= ST_NEW_CHK;
                            end
                        end else begin
                            d_reg     <= d_reg + 1'b1;
                            state_reg <= ST_NEW_RD;
                        end
                    end
                end
                ST_ITER: begin
                    iter_reg <= iter_reg + 1'b1;
                    c_reg    <= '0;
                    d_reg    <= '0;
                    if (conv_reg || 32'(iter_reg) + 1 >= MAX_ITERATIONS) state_reg <= ST_EMIT_RD;
                    else state_reg <= ST_CLR;
                end
                ST_EMIT_RD: state_reg <= ST_EMIT_LD;
                ST_EMIT_LD: begin
                    m_valid_reg   <= 1'b1;
                    m_cluster_reg <= 3'(c_reg);
                    m_dim_reg     <= 3'(d_reg);
                    m_value_reg   <= cm_q;
                    m_count_reg   <= 9'(cnt_reg[cl_idx]);
                    m_rad_reg     <= 35'(rad_reg[cl_idx]);
                    m_conv_reg    <= conv_reg;
                    m_status_reg  <= dropped_reg ? kmc_pkg::STATUS_DROPPED :
                                     (pcount_reg == '0) ? kmc_pkg::STATUS_NO_POINTS :
                                     kmc_pkg::STATUS_OK;
                    m_last_reg    <= d_last && c_last;
                    state_reg     <= ST_EMIT_WAIT;
                end
                ST_EMIT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_EMIT_RD;
                            if (d_last) begin
                                d_reg <= '0;
                                c_reg <= c_reg + 1'b1;
                            end else begin
                                d_reg <= d_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_cluster_index  = m_cluster_reg;
    assign m_out_dim        = m_dim_reg;
    assign m_centroid_value = $signed(m_value_reg);
    assign m_member_count   = m_count_reg;
    assign m_radius_squared = m_rad_reg;
    assign m_converged      = m_conv_reg;
    assign m_status         = m_status_reg;
    assign m_last           = m_last_reg;

endmodule

@@ bench/tb_kmeans_clustering_multidim_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the k-means clustering block.
// Bound, coordinate, clear and run requests go in over the s_ channel; a
// behavioral Lloyd's-algorithm predictor keeps its own copy of the points,
// bounds, LFSR and registers. Each accepted run queues k*nd expected centroid
// records, and the m_ side pops and compares them field by field.
// Both channels idle at random between transfers, with some
// stretches at full rate.
module tb_kmeans_clustering_multidim_top;

    localparam int NPTS  = 256;
    localparam int NCLU  = 8;
    localparam int NDIM  = 8;
    localparam int NPASS = 100;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = '0;
    logic [2:0]         s_dim_index = '0;
    logic signed [15:0] s_sample_value = '0;
    logic signed [15:0] s_upper_bound_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_cluster_index;
    logic [2:0]         m_out_dim;
    logic signed [15:0] m_centroid_value;
    logic [8:0]         m_member_count;
    logic [34:0]        m_radius_squared;
    logic               m_converged;
    logic [1:0]         m_status;
    logic               m_last;

    kmeans_clustering_multidim_top dut (.*);

    always #4 aclk = ~aclk;

    // one centroid coordinate record as the block should emit it
    typedef struct {
        logic [2:0]  clu;
        logic [2:0]  dim;
        logic [15:0] cent;
        logic [8:0]  members;
        logic [34:0] radius;
        logic        conv;
        logic [1:0]  status;
        logic        last;
    } centroid_rec_t;

    centroid_rec_t centroid_q[$];

    // predictor state
    logic [3:0]  k_reg = kmc_pkg::RESET_NUM_CLUSTERS;
    logic [3:0]  nd_reg = kmc_pkg::RESET_NUM_DIMS;
    logic [31:0] lfsr = 32'd1;
    shortint     pts[NPTS][NDIM];
    int          npts = 0;
    bit          dropped = 0;
    shortint     lo_b[NDIM];
    shortint     hi_b[NDIM];
    shortint     cent[NCLU][NDIM];
    int          members[NCLU];
    longint      radius[NCLU];

    int  errs = 0;
    int  sent = 0;
    bit  src_busy_free = 0;   // 1: sender runs back to back
    bit  snk_busy_free = 0;   // 1: receiver never stalls

    function automatic int eff_size(logic [3:0] v);
        if (v == 0) return 1;
        return (v > 8) ? 8 : int'(v);
    endfunction

    // Lloyd run: seed from LFSR, iterate to a fixed point or the pass cap,
    // then queue one record per (cluster, dim), cluster-major
    task automatic predict_run();
        int     k, nd, c, d, p, best, passes;
        bit     conv;
        longint sums[NCLU][NDIM];
        longint s, bestd, df, prod, dlt;
        centroid_rec_t r;
        shortint nv;
        k = eff_size(k_reg);
        nd = eff_size(nd_reg);
        for (c = 0; c < k; c++) begin
            for (d = 0; d < nd; d++) begin
                lfsr = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? kmc_pkg::LFSR_TAPS : 32'd0);
                dlt = longint'(hi_b[d]) - longint'(lo_b[d]);
                prod = dlt * longint'({32'd0, lfsr});
                cent[c][d] = shortint'(longint'(lo_b[d]) + (prod >>> 32));
            end
            radius[c] = 0;
            members[c] = 0;
        end
        conv = 0;
        passes = 0;
        while (!conv && passes < NPASS) begin
            for (c = 0; c < k; c++) begin
                members[c] = 0;
                for (d = 0; d < nd; d++) sums[c][d] = 0;
            end
            for (p = 0; p < npts; p++) begin
                best = 0;
                bestd = 0;
                for (c = 0; c < k; c++) begin
                    s = 0;
                    for (d = 0; d < nd; d++) begin
                        df = longint'(pts[p][d]) - longint'(cent[c][d]);
                        s += df * df;
                    end
                    // strict less-than keeps the lowest index on ties
                    if (c == 0 || s < bestd) begin
                        bestd = s;
                        best = c;
                    end
                end
                if (bestd > radius[best]) radius[best] = bestd;
                members[best]++;
                for (d = 0; d < nd; d++) sums[best][d] += pts[p][d];
            end
            conv = 1;
            for (c = 0; c < k; c++) begin
                if (members[c] != 0) begin
                    for (d = 0; d < nd; d++) begin
                        nv = shortint'(sums[c][d] / longint'(members[c]));
                        if (nv != cent[c][d]) conv = 0;
                        cent[c][d] = nv;
                    end
                end
            end
            passes++;
        end
        for (c = 0; c < k; c++) begin
            for (d = 0; d < nd; d++) begin
                r.clu = c[2:0];
                r.dim = d[2:0];
                r.cent = cent[c][d];
                r.members = members[c][8:0];
                r.radius = radius[c][34:0];
                r.conv = conv;
                r.status = dropped ? kmc_pkg::STATUS_DROPPED :
                           (npts == 0 ? kmc_pkg::STATUS_NO_POINTS : kmc_pkg::STATUS_OK);
                r.last = (c == k - 1 && d == nd - 1);
                centroid_q = {centroid_q, r};
            end
        end
    endtask

    // apply one accepted request to the predictor
    task automatic model_request(kmc_pkg::cmd_t cmd, logic [2:0] dim, shortint sv,
                                 shortint uv);
        case (cmd)
            kmc_pkg::CMD_LOAD_COORD: begin
                if (npts < NPTS) pts[npts][dim] = sv;
                if (int'(dim) == eff_size(nd_reg) - 1) begin
                    if (npts < NPTS) npts++;
                    else dropped = 1;
                end
            end
            kmc_pkg::CMD_LOAD_BOUND: begin
                lo_b[dim] = sv;
                hi_b[dim] = uv;
            end
            kmc_pkg::CMD_CLEAR: begin
                npts = 0;
                dropped = 0;
            end
            default: predict_run();
        endcase
    endtask

    // drive one request and hold it until the handshake
    task automatic send_req(kmc_pkg::cmd_t cmd, logic [2:0] dim, shortint sv,
                            shortint uv = 0);
        int gap;
        gap = src_busy_free ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_command = cmd;
        s_dim_index = dim;
        s_sample_value = sv;
        s_upper_bound_value = uv;
        do @(posedge aclk); while (!s_ready);
        model_request(cmd, dim, sv, uv);
        sent++;
    endtask

    // one complete point, every dim in use written in order
    task automatic send_point(bit wild = 0);
        int d;
        shortint v;
        for (d = 0; d < eff_size(nd_reg); d++) begin
            case ($urandom_range(0, 7))
                0: v = 16'sh7FFF;
                1: v = -16'sh8000;
                default: v = wild ? shortint'($urandom()) :
                             shortint'(int'($urandom_range(0, 4095)) - 2048);
            endcase
            send_req(kmc_pkg::CMD_LOAD_COORD, d[2:0], v);
        end
    endtask

    // wait until no result is owed and the sequencer has gone quiet
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (centroid_q.size() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            kmc_pkg::CFG_NUM_CLUSTERS: k_reg = val[3:0];
            kmc_pkg::CFG_NUM_DIMS:     nd_reg = val[3:0];
            kmc_pkg::CFG_RNG_SEED:     lfsr = (val == 0) ? 32'd1 : val;
            default: ;
        endcase
    endtask

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errs++;
        end
    endtask

    // result side: random stalls, compare each accepted record
    initial begin
        int stall;
        centroid_rec_t e;
        forever begin
            stall = snk_busy_free ? 0 : $urandom_range(0, 15);
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (centroid_q.size() == 0) begin
                $error("unexpected result: cluster %0d dim %0d", m_cluster_index, m_out_dim);
                errs++;
            end else begin
                e = centroid_q.pop_front();
                check_field("cluster_index", e.clu, m_cluster_index);
                check_field("out_dim", e.dim, m_out_dim);
                check_field("centroid_value", $signed(e.cent), m_centroid_value);
                check_field("member_count", e.members, m_member_count);
                check_field("radius_squared", e.radius, m_radius_squared);
                check_field("converged", e.conv, m_converged);
                check_field("status", e.status, m_status);
                check_field("last", e.last, m_last);
            end
        end
    end

    // reset defaults, no points: seeds at zero bounds, status no-points;
    // then reversed and full-scale bounds on the edge dims
    task automatic test_empty_runs();
        send_req(kmc_pkg::CMD_RUN, 3'd0, 0);
        send_req(kmc_pkg::CMD_LOAD_BOUND, 3'd0, 16'sh7FFF, -16'sh8000);
        send_req(kmc_pkg::CMD_LOAD_BOUND, 3'd7, -16'sh8000, 16'sh7FFF);
        send_req(kmc_pkg::CMD_LOAD_BOUND, 3'd3, 16'sh0100, 16'sh0100);
        send_req(kmc_pkg::CMD_RUN, 3'd0, 0);
        settle();
    endtask

    // small set with extremes, an abandoned partial point and a clear
    task automatic test_small_set();
        write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 32'd3);
        write_reg(kmc_pkg::CFG_NUM_DIMS, 32'd2);
        write_reg(kmc_pkg::CFG_RNG_SEED, 32'd0);   // zero seed loads as one
        send_req(kmc_pkg::CMD_LOAD_BOUND, 3'd0, -16'sh0400, 16'sh0400);
        send_req(kmc_pkg::CMD_LOAD_BOUND, 3'd1, 16'sh0200, -16'sh0200);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd0, 16'sh7FFF);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd1, 16'sh7FFF);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd0, -16'sh8000);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd1, -16'sh8000);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd0, 16'sh0011);   // partial, rewritten below
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd0, 16'sh0000);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd1, 16'sh0000);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd0, -16'sh0001);
        send_req(kmc_pkg::CMD_LOAD_COORD, 3'd1, 16'sh0001);
        send_req(kmc_pkg::CMD_RUN, 3'd0, 0);
        send_req(kmc_pkg::CMD_CLEAR, 3'd0, 0);
        send_req(kmc_pkg::CMD_RUN, 3'd0, 0);
        settle();
    endtask

    // widest shape: k and nd above range saturate to 8, 64 records
    task automatic test_full_shape();
        int i;
        write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 32'd15);
        write_reg(kmc_pkg::CFG_NUM_DIMS, 32'd15);
        write_reg(kmc_pkg::CFG_RNG_SEED, 32'hFFFF_FFFF);
        send_req(kmc_pkg::CMD_CLEAR, 3'd0, 0);
        for (i = 0; i < 3; i++) send_point(1);
        send_req(kmc_pkg::CMD_RUN, 3'd0, 0);
        settle();
    endtask

    // fill past capacity with one-dim points: dropped status, then clear
    task automatic test_capacity();
        int i;
        write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 32'd2);
        write_reg(kmc_pkg::CFG_NUM_DIMS, 32'd0);   // zero is taken as one dim
        send_req(kmc_pkg::CMD_CLEAR, 3'd0, 0);
        src_busy_free = 1;
        for (i = 0; i < NPTS + 3; i++)
            send_req(kmc_pkg::CMD_LOAD_COORD, 3'd0,
                     shortint'(int'($urandom_range(0, 8191)) - 4096));
        src_busy_free = 0;
        send_req(kmc_pkg::CMD_RUN, 3'd0, 0);
        send_req(kmc_pkg::CMD_CLEAR, 3'd0, 0);
        send_req(kmc_pkg::CMD_RUN, 3'd0, 0);
        settle();
    endtask

    // random phases: config, then mostly well-formed points with some
    // bound loads, partial points and clears mixed in, closed by a run
    task automatic test_random();
        int start, n, i, j, d;
        start = sent;
        while (sent - start < 30) begin
            src_busy_free = ($urandom_range(0, 3) == 0);
            snk_busy_free = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                write_reg(kmc_pkg::CFG_NUM_CLUSTERS, $urandom_range(0, 15));
            write_reg(kmc_pkg::CFG_NUM_DIMS, $urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0) write_reg(kmc_pkg::CFG_RNG_SEED, $urandom());
            send_req(kmc_pkg::CMD_CLEAR, 3'($urandom()), shortint'($urandom()));
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 11))
                    0, 1: send_req(kmc_pkg::CMD_LOAD_BOUND, 3'($urandom()),
                                   shortint'($urandom()), shortint'($urandom()));
                    2: if (eff_size(nd_reg) > 1) begin
                        j = $urandom_range(0, eff_size(nd_reg) - 2);
                        for (d = 0; d <= j; d++)
                            send_req(kmc_pkg::CMD_LOAD_COORD, d[2:0], shortint'($urandom()));
                    end
                    3: if ($urandom_range(0, 3) == 0) send_req(kmc_pkg::CMD_CLEAR, 3'd0, 0);
                    default: send_point($urandom_range(0, 1));
                endcase
            end
            send_req(kmc_pkg::CMD_RUN, 3'($urandom()), shortint'($urandom()),
                     shortint'($urandom()));
            settle();
        end
        src_busy_free = 0;
        snk_busy_free = 0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_empty_runs();
        test_small_set();
        test_full_shape();
        test_capacity();
        test_random();
        settle();
        if (errs == 0)
            $display("kmeans_clustering_multidim_top: match");
        else
            $display("kmeans_clustering_multidim_top: mismatch");
        $finish;
    end

    // hang guard
    initial begin
        #400_000_000;
        $display("kmeans_clustering_multidim_top: mismatch");
        $finish;
    end

endmodule
